// ===== sv/tatt_pkg.sv =====
package tatt_pkg;

    localparam int IDX_W       = 8;
    localparam int REG_W       = 22;
    localparam int FRAC_W      = 16;
    localparam int DIST_W      = IDX_W + REG_W;
    localparam int DIVN_W      = DIST_W + FRAC_W;
    localparam int SQA_W       = DIVN_W + FRAC_W;
    localparam int ROOT_W      = SQA_W / 2;
    localparam int SREM_W      = ROOT_W + 2;
    localparam int TIME_W      = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_REGS    = 6;
    localparam int DIV_STAGES  = DIVN_W;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLUMNS = 256;

    localparam logic [REG_W-1:0]  REG_RESET = REG_W'(65536);
    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [IDX_W:0]    ROW_LIMIT = (IDX_W+1)'(MAX_ROWS);
    localparam logic [IDX_W:0]    COL_LIMIT = (IDX_W+1)'(MAX_COLUMNS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_H_PITCH = 3'd0,
        REG_V_PITCH = 3'd1,
        REG_H_SPEED = 3'd2,
        REG_H_ACCEL = 3'd3,
        REG_V_SPEED = 3'd4,
        REG_V_ACCEL = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [DIVN_W-1:0] qd;
        logic [REG_W-1:0]  rem;
    } div_t;

    typedef struct packed {
        logic [SQA_W-1:0]  arg;
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic zero;
        logic bad;
        logic trap;
        div_t q1;
        div_t q2;
    } axis_t;

    typedef struct packed {
        axis_t ax;
        sqrt_t s;
    } sq_axis_t;

    function automatic div_t div_step(div_t s, logic [REG_W-1:0] dv);
        logic [REG_W:0] sh;
        div_t o;
        sh = {s.rem, s.qd[DIVN_W-1]};
        o.qd = {s.qd[DIVN_W-2:0], 1'b0};
        if (sh >= {1'b0, dv})
        begin
            o.rem = REG_W'(sh - {1'b0, dv});
            o.qd[0] = 1'b1;
        end
        else
        begin
            o.rem = sh[REG_W-1:0];
        end
        return o;
    endfunction

    function automatic sqrt_t sqrt_step(sqrt_t s);
        logic [SREM_W+1:0] sh;
        logic [SREM_W+1:0] trial;
        sqrt_t o;
        sh = {s.rem, s.arg[SQA_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        o.arg = {s.arg[SQA_W-3:0], 2'b00};
        if (sh >= trial)
        begin
            o.rem = SREM_W'(sh - trial);
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = sh[SREM_W-1:0];
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== sv/two_axis_travel_time.sv =====
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | start_row start_column goal_row goal_column
// out     | out_valid | out_stall | travel_time time_saturated
// cfg     | cfg_write | -         | cfg_index cfg_data
//
// One word per cycle when out_stall does not hold the pipeline; three front stages,
// one divider setup stage, 46 divider stages (one quotient bit each), one square root
// setup stage, 31 square root stages (one root bit each) and the output register.
// rst_n clears all valid bits and loads every configuration register with 1.0.
// out_stall with a waiting word freezes the whole pipeline and raises in_stall.
module two_axis_travel_time (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [tatt_pkg::IDX_W-1:0]             start_row,
    input  logic [tatt_pkg::IDX_W-1:0]             start_column,
    input  logic [tatt_pkg::IDX_W-1:0]             goal_row,
    input  logic [tatt_pkg::IDX_W-1:0]             goal_column,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [tatt_pkg::TIME_W-1:0]            travel_time,
    output logic                                   time_saturated,
    input  logic                                   cfg_write,
    input  logic [tatt_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tatt_pkg::REG_W-1:0]             cfg_data
);

    localparam int ND = tatt_pkg::DIV_STAGES;
    localparam int NS = tatt_pkg::SQRT_STAGES;

    logic adv;

    logic [tatt_pkg::REG_W-1:0] cfg_reg [tatt_pkg::NUM_REGS];
    logic [tatt_pkg::REG_W-1:0] pitch [2];
    logic [tatt_pkg::REG_W-1:0] speed [2];
    logic [tatt_pkg::REG_W-1:0] accel [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tatt_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= tatt_pkg::REG_RESET;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tatt_pkg::REG_H_PITCH: cfg_reg[tatt_pkg::REG_H_PITCH] <= cfg_data;
                tatt_pkg::REG_V_PITCH: cfg_reg[tatt_pkg::REG_V_PITCH] <= cfg_data;
                tatt_pkg::REG_H_SPEED: cfg_reg[tatt_pkg::REG_H_SPEED] <= cfg_data;
                tatt_pkg::REG_H_ACCEL: cfg_reg[tatt_pkg::REG_H_ACCEL] <= cfg_data;
                tatt_pkg::REG_V_SPEED: cfg_reg[tatt_pkg::REG_V_SPEED] <= cfg_data;
                tatt_pkg::REG_V_ACCEL: cfg_reg[tatt_pkg::REG_V_ACCEL] <= cfg_data;
                default: ;
            endcase
        end
    end

    // axis 0 horizontal, axis 1 vertical
    assign pitch[0] = cfg_reg[tatt_pkg::REG_H_PITCH];
    assign pitch[1] = cfg_reg[tatt_pkg::REG_V_PITCH];
    assign speed[0] = cfg_reg[tatt_pkg::REG_H_SPEED];
    assign accel[0] = cfg_reg[tatt_pkg::REG_H_ACCEL];
    assign speed[1] = cfg_reg[tatt_pkg::REG_V_SPEED];
    assign accel[1] = cfg_reg[tatt_pkg::REG_V_ACCEL];

    logic out_valid_reg;
    assign adv = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // stage a: clamp indices
    logic a_valid_reg;
    logic [tatt_pkg::IDX_W-1:0] a_s_reg [2];
    logic [tatt_pkg::IDX_W-1:0] a_g_reg [2];
    logic [tatt_pkg::IDX_W-1:0] a_s_next [2];
    logic [tatt_pkg::IDX_W-1:0] a_g_next [2];

    always_comb
    begin
        a_s_next[0] = ({1'b0, start_column} >= tatt_pkg::COL_LIMIT) ?
                      tatt_pkg::IDX_W'(tatt_pkg::MAX_COLUMNS - 1) : start_column;
        a_g_next[0] = ({1'b0, goal_column} >= tatt_pkg::COL_LIMIT) ?
                      tatt_pkg::IDX_W'(tatt_pkg::MAX_COLUMNS - 1) : goal_column;
        a_s_next[1] = ({1'b0, start_row} >= tatt_pkg::ROW_LIMIT) ?
                      tatt_pkg::IDX_W'(tatt_pkg::MAX_ROWS - 1) : start_row;
        a_g_next[1] = ({1'b0, goal_row} >= tatt_pkg::ROW_LIMIT) ?
                      tatt_pkg::IDX_W'(tatt_pkg::MAX_ROWS - 1) : goal_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_s_reg <= a_s_next;
            a_g_reg <= a_g_next;
        end
    end

    // stage b: distance
    logic b_valid_reg;
    logic [tatt_pkg::DIST_W-1:0] b_d_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int x = 0; x < 2; x++)
            begin
                b_d_reg[x] <= tatt_pkg::DIST_W'(
                    (a_s_reg[x] > a_g_reg[x]) ? a_s_reg[x] - a_g_reg[x]
                                              : a_g_reg[x] - a_s_reg[x])
                    * tatt_pkg::DIST_W'(pitch[x]);
            end
        end
    end

    // stage c: profile products
    localparam int DA_W = tatt_pkg::DIST_W + tatt_pkg::REG_W;
    localparam int VV_W = 2 * tatt_pkg::REG_W;

    logic c_valid_reg;
    logic [tatt_pkg::DIST_W-1:0] c_d_reg [2];
    logic [DA_W-1:0] c_da_reg [2];
    logic [VV_W-1:0] c_vv_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int x = 0; x < 2; x++)
            begin
                c_d_reg[x] <= b_d_reg[x];
                c_da_reg[x] <= DA_W'(b_d_reg[x]) * DA_W'(accel[x]);
                c_vv_reg[x] <= VV_W'(speed[x]) * VV_W'(speed[x]);
            end
        end
    end

    // divider pipeline
    logic div_valid_reg [ND+1];
    tatt_pkg::axis_t div_reg [ND+1][2];
    tatt_pkg::axis_t div_next [2];

    always_comb
    begin
        for (int x = 0; x < 2; x++)
        begin
            div_next[x].zero = (c_d_reg[x] == '0);
            div_next[x].bad = (speed[x] == '0) || (accel[x] == '0);
            div_next[x].trap = (c_da_reg[x] > DA_W'(c_vv_reg[x]));
            div_next[x].q1.qd = div_next[x].trap ?
                tatt_pkg::DIVN_W'({speed[x], {tatt_pkg::FRAC_W{1'b0}}}) :
                {c_d_reg[x], {tatt_pkg::FRAC_W{1'b0}}};
            div_next[x].q1.rem = '0;
            div_next[x].q2.qd = {c_d_reg[x], {tatt_pkg::FRAC_W{1'b0}}};
            div_next[x].q2.rem = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ND; k++)
            begin
                div_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            div_valid_reg[0] <= c_valid_reg;
            for (int k = 1; k <= ND; k++)
            begin
                div_valid_reg[k] <= div_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0] <= div_next;
            for (int k = 1; k <= ND; k++)
            begin
                for (int x = 0; x < 2; x++)
                begin
                    div_reg[k][x].zero <= div_reg[k-1][x].zero;
                    div_reg[k][x].bad <= div_reg[k-1][x].bad;
                    div_reg[k][x].trap <= div_reg[k-1][x].trap;
                    div_reg[k][x].q1 <= tatt_pkg::div_step(div_reg[k-1][x].q1, accel[x]);
                    div_reg[k][x].q2 <= tatt_pkg::div_step(div_reg[k-1][x].q2, speed[x]);
                end
            end
        end
    end

    // square root pipeline
    logic sq_valid_reg [NS+1];
    tatt_pkg::sq_axis_t sq_reg [NS+1][2];
    tatt_pkg::sq_axis_t sq_next [2];

    always_comb
    begin
        for (int x = 0; x < 2; x++)
        begin
            sq_next[x].ax = div_reg[ND][x];
            sq_next[x].s.arg = {div_reg[ND][x].q1.qd, {tatt_pkg::FRAC_W{1'b0}}};
            sq_next[x].s.rem = '0;
            sq_next[x].s.root = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= NS; j++)
            begin
                sq_valid_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            sq_valid_reg[0] <= div_valid_reg[ND];
            for (int j = 1; j <= NS; j++)
            begin
                sq_valid_reg[j] <= sq_valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0] <= sq_next;
            for (int j = 1; j <= NS; j++)
            begin
                for (int x = 0; x < 2; x++)
                begin
                    sq_reg[j][x].ax <= sq_reg[j-1][x].ax;
                    sq_reg[j][x].s <= tatt_pkg::sqrt_step(sq_reg[j-1][x].s);
                end
            end
        end
    end

    // output stage
    logic [tatt_pkg::TIME_W-1:0] t_axis [2];
    logic sat_next;
    logic [tatt_pkg::TIME_W-1:0] time_next;
    logic [tatt_pkg::TIME_W-1:0] time_reg;
    logic sat_reg;

    always_comb
    begin
        sat_next = 1'b0;
        for (int x = 0; x < 2; x++)
        begin
            if (sq_reg[NS][x].ax.zero)
            begin
                t_axis[x] = '0;
            end
            else if (sq_reg[NS][x].ax.bad)
            begin
                t_axis[x] = tatt_pkg::TIME_MAX;
                sat_next = 1'b1;
            end
            else if (sq_reg[NS][x].ax.trap)
            begin
                t_axis[x] = tatt_pkg::TIME_W'(sq_reg[NS][x].ax.q1.qd)
                          + tatt_pkg::TIME_W'(sq_reg[NS][x].ax.q2.qd);
            end
            else
            begin
                t_axis[x] = tatt_pkg::TIME_W'({sq_reg[NS][x].s.root, 1'b0});
            end
        end
        time_next = (t_axis[0] > t_axis[1]) ? t_axis[0] : t_axis[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= sq_valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            time_reg <= time_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign travel_time = time_reg;
    assign time_saturated = sat_reg;

`ifndef SYNTHESIS
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && time_saturated |-> (travel_time == tatt_pkg::TIME_MAX))
        else $error("saturated word without maximum time");

    a_div_rem_h: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[ND] && !div_reg[ND][0].bad |->
            (div_reg[ND][0].q1.rem < accel[0]) && (div_reg[ND][0].q2.rem < speed[0]))
        else $error("horizontal divider remainder out of range");

    a_div_rem_v: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[ND] && !div_reg[ND][1].bad |->
            (div_reg[ND][1].q1.rem < accel[1]) && (div_reg[ND][1].q2.rem < speed[1]))
        else $error("vertical divider remainder out of range");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(sq_valid_reg[NS]) && $stable(div_valid_reg[ND]))
        else $error("pipeline moved while output stalled");
`endif

endmodule

// ===== tb/sv/two_axis_travel_time_test.sv =====
module two_axis_travel_time_test;

    localparam logic [tatt_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [tatt_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam logic [tatt_pkg::REG_W-1:0]     REG_TOP     = {tatt_pkg::REG_W{1'b1}};
    localparam int                             DRAIN       = 120;

    typedef struct {
        logic [tatt_pkg::IDX_W-1:0] sr;
        logic [tatt_pkg::IDX_W-1:0] sc;
        logic [tatt_pkg::IDX_W-1:0] gr;
        logic [tatt_pkg::IDX_W-1:0] gc;
    } slot_pair_t;

    typedef struct {
        logic [tatt_pkg::TIME_W-1:0] t;
        logic                        sat;
    } travel_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [tatt_pkg::IDX_W-1:0]     start_row;
    logic [tatt_pkg::IDX_W-1:0]     start_column;
    logic [tatt_pkg::IDX_W-1:0]     goal_row;
    logic [tatt_pkg::IDX_W-1:0]     goal_column;
    logic                           out_valid;
    logic                           out_stall;
    logic [tatt_pkg::TIME_W-1:0]    travel_time;
    logic                           time_saturated;
    logic                           cfg_write;
    logic [tatt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tatt_pkg::REG_W-1:0]     cfg_data;

    logic [tatt_pkg::REG_W-1:0] regs [tatt_pkg::NUM_REGS];
    slot_pair_t       pending_pairs [$];
    travel_t          expected_times [$];
    int               send_idle_pct;
    int               stall_pct;
    bit               word_taken;
    int               errors;

    two_axis_travel_time u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_row(start_row), .start_column(start_column),
        .goal_row(goal_row), .goal_column(goal_column),
        .out_valid(out_valid), .out_stall(out_stall),
        .travel_time(travel_time), .time_saturated(time_saturated),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic travel_t axis_travel(logic [tatt_pkg::IDX_W-1:0] p,
                                            logic [tatt_pkg::IDX_W-1:0] q,
                                            logic [tatt_pkg::REG_W-1:0] pitch,
                                            logic [tatt_pkg::REG_W-1:0] v,
                                            logic [tatt_pkg::REG_W-1:0] a);
        longint unsigned span;
        longint unsigned vv;
        longint unsigned aa;
        longint unsigned t;
        travel_t r;
        span = 64'(p > q ? p - q : q - p) * 64'(pitch);
        vv = 64'(v);
        aa = 64'(a);
        r.sat = 1'b0;
        r.t = '0;
        if (span == 0)
            return r;
        if (vv == 0 || aa == 0)
        begin
            r.sat = 1'b1;
            r.t = tatt_pkg::TIME_MAX;
            return r;
        end
        if (span * aa > vv * vv)
            t = ((vv << 16) / aa) + ((span << 16) / vv);
        else
            t = 64'd2 * floor_sqrt(((span << 16) / aa) << 16);
        if (t > 64'(tatt_pkg::TIME_MAX))
        begin
            r.sat = 1'b1;
            r.t = tatt_pkg::TIME_MAX;
        end
        else
        begin
            r.t = t[tatt_pkg::TIME_W-1:0];
        end
        return r;
    endfunction

    function automatic travel_t predict_travel(slot_pair_t w);
        travel_t h;
        travel_t v;
        travel_t r;
        h = axis_travel(w.sc, w.gc, regs[tatt_pkg::REG_H_PITCH],
                        regs[tatt_pkg::REG_H_SPEED], regs[tatt_pkg::REG_H_ACCEL]);
        v = axis_travel(w.sr, w.gr, regs[tatt_pkg::REG_V_PITCH],
                        regs[tatt_pkg::REG_V_SPEED], regs[tatt_pkg::REG_V_ACCEL]);
        r.t = h.t > v.t ? h.t : v.t;
        r.sat = h.sat | v.sat;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || word_taken)
            begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    start_row <= pending_pairs[0].sr;
                    start_column <= pending_pairs[0].sc;
                    goal_row <= pending_pairs[0].gr;
                    goal_column <= pending_pairs[0].gc;
                    void'(pending_pairs.pop_front());
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            word_taken = 1'b0;
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        slot_pair_t w;
        travel_t e;
        if (rst_n && in_valid && !in_stall)
        begin
            w.sr = start_row;
            w.sc = start_column;
            w.gr = goal_row;
            w.gc = goal_column;
            expected_times.push_back(predict_travel(w));
            word_taken = 1'b1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_times.size() == 0)
            begin
                $error("unexpected word: travel_time %0h", travel_time);
                errors++;
            end
            else
            begin
                e = expected_times.pop_front();
                if (travel_time !== e.t)
                begin
                    $error("travel_time expected %0h actual %0h", e.t, travel_time);
                    errors++;
                end
                if (time_saturated !== e.sat)
                begin
                    $error("time_saturated expected %0b actual %0b", e.sat, time_saturated);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [tatt_pkg::CFG_IDX_W-1:0] idx,
                             logic [tatt_pkg::REG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx < tatt_pkg::NUM_REGS)
            regs[idx] = val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_axes(logic [tatt_pkg::REG_W-1:0] hp, logic [tatt_pkg::REG_W-1:0] vp,
                            logic [tatt_pkg::REG_W-1:0] hv, logic [tatt_pkg::REG_W-1:0] ha,
                            logic [tatt_pkg::REG_W-1:0] vv, logic [tatt_pkg::REG_W-1:0] va);
        write_reg(tatt_pkg::REG_H_PITCH, hp);
        write_reg(tatt_pkg::REG_V_PITCH, vp);
        write_reg(tatt_pkg::REG_H_SPEED, hv);
        write_reg(tatt_pkg::REG_H_ACCEL, ha);
        write_reg(tatt_pkg::REG_V_SPEED, vv);
        write_reg(tatt_pkg::REG_V_ACCEL, va);
    endtask

    task automatic queue_pair(int sr, int sc, int gr, int gc);
        slot_pair_t w;
        w.sr = tatt_pkg::IDX_W'(sr);
        w.sc = tatt_pkg::IDX_W'(sc);
        w.gr = tatt_pkg::IDX_W'(gr);
        w.gc = tatt_pkg::IDX_W'(gc);
        pending_pairs.push_back(w);
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || in_valid || expected_times.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic queue_random(int n);
        int base;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0: queue_pair($urandom_range(255), $urandom_range(255),
                              $urandom_range(255), $urandom_range(255));
                1:
                begin
                    base = $urandom_range(255);
                    queue_pair(base, $urandom_range(255), base, $urandom_range(255));
                end
                2: queue_pair($urandom_range(3), $urandom_range(3),
                              $urandom_range(3), $urandom_range(3));
                default: queue_pair($urandom_range(255), $urandom_range(255),
                                    $urandom_range(255), $urandom_range(255));
            endcase
        end
    endtask

    task automatic run_phase(int idle, int stall, int n);
        send_idle_pct = idle;
        stall_pct = stall;
        queue_random(n);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        start_row = '0;
        start_column = '0;
        goal_row = '0;
        goal_column = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        word_taken = 1'b0;
        errors = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < tatt_pkg::NUM_REGS; i++)
            regs[i] = tatt_pkg::REG_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_pair(0, 0, 0, 0);
        queue_pair(0, 0, 255, 255);
        queue_pair(255, 255, 0, 0);
        queue_pair(0, 255, 0, 0);
        queue_pair(255, 0, 0, 0);
        queue_pair(1, 1, 0, 0);
        queue_pair(0, 0, 1, 2);
        queue_pair(0, 0, 4, 1);
        queue_pair(170, 85, 85, 170);
        queue_pair(128, 128, 128, 128);
        wait_drained();

        write_reg(REG_SPARE_6, 22'h0);
        write_reg(REG_SPARE_7, 22'h0);
        set_axes(REG_TOP, REG_TOP, 22'd1, 22'd1, REG_TOP, REG_TOP);
        queue_pair(0, 0, 255, 255);
        queue_pair(255, 255, 0, 0);
        queue_pair(0, 0, 0, 1);
        queue_pair(0, 0, 1, 0);
        wait_drained();

        set_axes(22'd0, 22'd1, 22'd0, 22'd0, 22'd1, 22'd0);
        queue_pair(0, 0, 255, 255);
        queue_pair(0, 0, 0, 7);
        queue_pair(3, 9, 3, 9);
        queue_pair(0, 0, 1, 0);
        wait_drained();

        set_axes(tatt_pkg::REG_RESET, tatt_pkg::REG_RESET, tatt_pkg::REG_RESET,
                 tatt_pkg::REG_RESET, tatt_pkg::REG_RESET, tatt_pkg::REG_RESET);
        run_phase(0, 0, 150);
        run_phase(46, 0, 150);
        run_phase(0, 46, 150);
        run_phase(37, 37, 150);

        set_axes(REG_TOP, 22'd1, REG_TOP, 22'd1, 22'd1, REG_TOP);
        run_phase(37, 37, 100);

        set_axes(22'd1, REG_TOP, 22'd1, REG_TOP, REG_TOP, 22'd1);
        run_phase(0, 46, 100);

        for (int k = 0; k < 4; k++)
        begin
            set_axes(tatt_pkg::REG_W'($urandom_range(REG_TOP)),
                     tatt_pkg::REG_W'($urandom_range(REG_TOP)),
                     tatt_pkg::REG_W'($urandom_range(1, REG_TOP)),
                     tatt_pkg::REG_W'($urandom_range(1, REG_TOP)),
                     tatt_pkg::REG_W'($urandom_range(1, REG_TOP)),
                     tatt_pkg::REG_W'($urandom_range(1, REG_TOP)));
            run_phase(k * 12, 46 - k * 12, 60);
        end

        set_axes(22'h15555, 22'h2AAAA, 22'h3FFFE, 22'h00001, 22'h20000, 22'h08000);
        send_idle_pct = 0;
        stall_pct = 46;
        queue_random(50);
        while (pending_pairs.size() > 0 || in_valid || expected_times.size() > 0)
            @(posedge clk);
        queue_random(50);
        wait_drained();

        if (errors == 0)
            $display("two_axis_travel_time_test: done, clean");
        else
            $display("two_axis_travel_time_test: done, errors");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("two_axis_travel_time_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tatt_pkg.sv
sv/two_axis_travel_time.sv
tb/sv/two_axis_travel_time_test.sv
